/* rtl/rpd_pkg.sv */
// Shared constants, field positions and types for the radius point dedup block.
package rpd_pkg;

  localparam int MAX_KEPT_DEF   = 16;
  localparam int COORD_BITS_DEF = 12;

  localparam int          RADIUS_W     = 8;
  localparam logic [7:0]  RADIUS_RESET = 8'd10;
  localparam int          R2_W         = 2 * RADIUS_W;

  // result fields, lowest bit first
  localparam int SLOT_W   = 4;
  localparam int TOTAL_W  = 5;
  localparam int OUT_W    = 16;
  localparam int ACC_POS  = 0;
  localparam int SLOT_LSB = 1;
  localparam int TOT_LSB  = SLOT_LSB + SLOT_W;
  localparam int DROP_POS = TOT_LSB + TOTAL_W;

  // status from the distance unit to the sequencer
  typedef struct packed {
    logic valid;
    logic near;
  } dist_res_t;

endpackage

/* rtl/rpd_ram.sv */
// Generic simple dual-port RAM with registered read.
module rpd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rpd_dist.sv */
// Shared distance unit: squared distance of one kept centre against the radius.
module rpd_dist
  import rpd_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic [COORD_BITS-1:0] kx,
  input  logic [COORD_BITS-1:0] ky,
  input  logic [R2_W-1:0]       r2,
  output dist_res_t             res
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;

  logic [COORD_BITS-1:0] dx, dy;
  logic [SQ_W-1:0]       dxw, dyw;
  logic [SQ_W-1:0]       sq_x_r, sq_y_r;
  logic                  v_r;
  logic [SUM_W-1:0]      sum;

  always_comb begin
    dx  = (px >= kx) ? (px - kx) : (kx - px);
    dy  = (py >= ky) ? (py - ky) : (ky - py);
    dxw = SQ_W'(dx);
    dyw = SQ_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_valid;
    end
    sq_x_r <= dxw * dxw;
    sq_y_r <= dyw * dyw;
  end

  assign sum       = SUM_W'(sq_x_r) + SUM_W'(sq_y_r);
  assign res.valid = v_r;
  assign res.near  = (sum < SUM_W'(r2));

endmodule

/* rtl/radius_point_dedup.sv */
// Top level of the radius point dedup block: sequencer, centre list and result register.
//
// Each offered centre is compared against every kept centre of the current set by one
// pipelined distance unit, one kept entry per cycle read from the centre RAM. An item
// goes through an accept step, a sweep over the kept entries (skipped for an empty
// list), a drain of the RAM read and distance pipeline, and a decision that writes
// the result register, appends an accepted centre, clears the list after the last of
// a set, and waits for a free output. in_tready is high only between items; a new
// item may be taken while the previous result still waits in the output register.
// The list needs no clearing pass: only entries below the count are ever read.
module radius_point_dedup
  import rpd_pkg::*;
#(
  parameter int MAX_KEPT   = MAX_KEPT_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IN_W      = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IN_W-1:0]     in_tdata,   // center_x, center_y, zero fill
  input  logic                in_tlast,   // last_of_set
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // accepted, slot[4], kept_total[5], dropped_full
  input  logic                cfg_wr_en,
  input  logic [RADIUS_W-1:0] cfg_wr_data
);

  localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int PT_W  = 2 * COORD_BITS;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  state_t                state_r;
  logic [RADIUS_W-1:0]   radius_r;
  logic [R2_W-1:0]       r2_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic                  last_r;
  logic [CNT_W-1:0]      count_r, idx_r;
  logic                  hit_r;
  logic                  rd_v_r;
  logic                  out_tvalid_r;
  logic [OUT_W-1:0]      out_tdata_r;

  logic                  in_xfer, out_free;
  logic                  full, acc;
  logic [CNT_W-1:0]      count_nxt;
  logic                  wr_en;
  logic [OUT_W-1:0]      res_word;
  logic [PT_W-1:0]       rd_data;
  dist_res_t             dist_res;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    full      = (count_r == CNT_W'(MAX_KEPT));
    acc       = !hit_r && !full;
    count_nxt = count_r + CNT_W'(acc);
    wr_en     = (state_r == S_DECIDE) && out_free && acc;
    res_word                          = '0;
    res_word[ACC_POS]                 = acc;
    res_word[TOT_LSB-1:SLOT_LSB]      = acc ? SLOT_W'(count_r) : '0;
    res_word[DROP_POS-1:TOT_LSB]      = TOTAL_W'(count_nxt);
    res_word[DROP_POS]                = !hit_r && full;
  end

  rpd_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_KEPT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({y_r, x_r}),
    .rd_en   (state_r == S_SCAN),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  rpd_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_v_r),
    .px       (x_r),
    .py       (y_r),
    .kx       (rd_data[COORD_BITS-1:0]),
    .ky       (rd_data[PT_W-1:COORD_BITS]),
    .r2       (r2_r),
    .res      (dist_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      radius_r     <= RADIUS_RESET;
      count_r      <= '0;
      idx_r        <= '0;
      hit_r        <= 1'b0;
      rd_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      rd_v_r <= (state_r == S_SCAN);
      if (dist_res.valid && dist_res.near) begin
        hit_r <= 1'b1;
      end
      // the decision cycle reloads the result register itself
      if (out_tvalid_r && out_tready && state_r != S_DECIDE) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            hit_r   <= 1'b0;
            idx_r   <= '0;
            state_r <= (count_r == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + CNT_W'(1);
          if (idx_r == count_r - CNT_W'(1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // wait until the last compare has folded into hit_r
          if (!rd_v_r && !dist_res.valid) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            count_r      <= last_r ? '0 : count_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r    <= in_tdata[COORD_BITS-1:0];
      y_r    <= in_tdata[PT_W-1:COORD_BITS];
      last_r <= in_tlast;
      r2_r   <= R2_W'(radius_r) * R2_W'(radius_r);
    end
    if (state_r == S_DECIDE && out_free) begin
      out_tdata_r <= res_word;
    end
  end

endmodule

/* rtl/rpd_checker.sv */
// Port-level assertions for the radius point dedup block, bound to the top level.
module rpd_checker
  import rpd_pkg::*;
#(
  parameter int MAX_KEPT = MAX_KEPT_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  logic [TOTAL_W-1:0] slot_plus1;
  assign slot_plus1 = TOTAL_W'(out_tdata[TOT_LSB-1:SLOT_LSB]) + TOTAL_W'(1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a point is either stored, dropped or a duplicate
  a_acc_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[ACC_POS] && out_tdata[DROP_POS]))
    else $error("accepted and dropped_full both set");

  // slot is zero unless the point was stored
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[ACC_POS] |-> out_tdata[TOT_LSB-1:SLOT_LSB] == '0)
    else $error("slot nonzero on rejected point");

  // a stored point is the newest entry of the list
  a_slot_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[ACC_POS] && (MAX_KEPT <= 16)
      |-> out_tdata[DROP_POS-1:TOT_LSB] == slot_plus1)
    else $error("kept_total does not follow slot");

  // a drop happens only with a full list
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[DROP_POS] |-> out_tdata[DROP_POS-1:TOT_LSB] == TOTAL_W'(MAX_KEPT))
    else $error("drop without full list");

endmodule

bind radius_point_dedup rpd_checker #(.MAX_KEPT(MAX_KEPT)) u_rpd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
